// File: rtl/core/input_binding_state_table_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the input binding state table core.
// Every macro samples on the rising edge of clk and is disabled while rst_n
// is low.
// ---------------------------------------------------------------------------
`ifndef INPUT_BINDING_STATE_TABLE_CORE_ASSERT_SVH
`define INPUT_BINDING_STATE_TABLE_CORE_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold as well.
`define IBST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the following cycle.
`define IBST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ibst_pkg.sv
// ---------------------------------------------------------------------------
// ibst_pkg
// Shared constants and codes of the input binding state table core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ibst_pkg;

  // Table geometry.
  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = 9;

  // Field widths.
  localparam int CMD_W    = 3;
  localparam int EIDX_W   = 8;
  localparam int DTYPE_W  = 16;
  localparam int DCODE_W  = 16;
  localparam int TIME_W   = 64;
  localparam int STATUS_W = 2;

  // Memory words: binding is {type, code}, entry state is {time, released}.
  localparam int BIND_W  = DTYPE_W + DCODE_W;
  localparam int STATE_W = TIME_W + 1;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REBIND  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PRESS   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FRAME   = 3'd5;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_IDX = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNUSED  = 2'd3;

endpackage

// File: rtl/core/ibst_ram.sv
// ---------------------------------------------------------------------------
// ibst_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ibst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/input_binding_state_table_core.sv
// ---------------------------------------------------------------------------
// input_binding_state_table_core
// Table of logical inputs bound to physical (type, code) pairs, with press
// times and released marks held in two table memories.
// ---------------------------------------------------------------------------
// One item is handled at a time. Allocate, rebind and unknown commands pass
// through an execute state to the result; a query adds a state for the
// memory read. Press and release walk the allocated entries through the
// single read port of the table memories, one entry per cycle, and stop
// at the first match, or after the last allocated entry with no match. A
// frame update always walks all allocated entries. The next item is
// accepted in the cycle the result turns valid; while a result waits on
// out_ready, the following result is held inside and the input stays closed.
// The memories have no reset and need no clearing pass: only entries below
// the allocation count are ever read, and each one is written when it is
// allocated.
`timescale 1ns / 1ps

module input_binding_state_table_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ibst_pkg::CMD_W-1:0]    in_cmd,
  input  logic [ibst_pkg::EIDX_W-1:0]   in_entry_index,
  input  logic [ibst_pkg::DTYPE_W-1:0]  in_dev_type,
  input  logic [ibst_pkg::DCODE_W-1:0]  in_dev_code,
  input  logic [ibst_pkg::TIME_W-1:0]   in_event_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ibst_pkg::EIDX_W-1:0]   out_alloc_index,
  output logic                          out_is_pressed,
  output logic                          out_matched,
  output logic [ibst_pkg::STATUS_W-1:0] out_status
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_QRD  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_r, state_nxt;

  // Captured item.
  logic [ibst_pkg::CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [ibst_pkg::EIDX_W-1:0]  idx_r, idx_nxt;
  logic [ibst_pkg::DTYPE_W-1:0] type_r, type_nxt;
  logic [ibst_pkg::DCODE_W-1:0] code_r, code_nxt;
  logic [ibst_pkg::TIME_W-1:0]  time_r, time_nxt;

  // Table control.
  logic [ibst_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [ibst_pkg::CNT_W-1:0] scan_r, scan_nxt;
  logic                       rd_vld_r, rd_vld_nxt;
  logic [ibst_pkg::IDX_W-1:0] rd_idx_r, rd_idx_nxt;

  // Pending result.
  logic [ibst_pkg::EIDX_W-1:0]   res_alloc_r, res_alloc_nxt;
  logic                          res_press_r, res_press_nxt;
  logic                          res_match_r, res_match_nxt;
  logic [ibst_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;

  // Output register.
  logic                          out_valid_r, out_valid_nxt;
  logic [ibst_pkg::EIDX_W-1:0]   out_alloc_r, out_alloc_nxt;
  logic                          out_press_r, out_press_nxt;
  logic                          out_match_r, out_match_nxt;
  logic [ibst_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;

  // Memory ports.
  logic                         b_we, s_we;
  logic [ibst_pkg::IDX_W-1:0]   b_waddr, s_waddr, raddr;
  logic [ibst_pkg::BIND_W-1:0]  b_wdata, b_rdata;
  logic [ibst_pkg::STATE_W-1:0] s_wdata, s_rdata;

  logic                        hit;
  logic [ibst_pkg::TIME_W-1:0] old_time;
  logic                        idx_bad;

  ibst_ram #(
    .WIDTH (ibst_pkg::BIND_W),
    .DEPTH (ibst_pkg::TABLE_ENTRIES)
  ) u_bind_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (raddr),
    .rdata (b_rdata)
  );

  ibst_ram #(
    .WIDTH (ibst_pkg::STATE_W),
    .DEPTH (ibst_pkg::TABLE_ENTRIES)
  ) u_state_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (raddr),
    .rdata (s_rdata)
  );

  // Decode helpers on the captured item and the read data.
  assign old_time = s_rdata[ibst_pkg::STATE_W-1:1];
  assign idx_bad  = ({1'b0, idx_r} >= count_r);
  assign hit      = rd_vld_r && (cmd_r != ibst_pkg::CMD_FRAME) &&
                    (b_rdata == {type_r, code_r});

  // Sequencer: capture, execute or scan, then hand the result over.
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    idx_nxt        = idx_r;
    type_nxt       = type_r;
    code_nxt       = code_r;
    time_nxt       = time_r;
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    res_alloc_nxt  = res_alloc_r;
    res_press_nxt  = res_press_r;
    res_match_nxt  = res_match_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_alloc_nxt  = out_alloc_r;
    out_press_nxt  = out_press_r;
    out_match_nxt  = out_match_r;
    out_status_nxt = out_status_r;
    b_we           = 1'b0;
    b_waddr        = count_r[ibst_pkg::IDX_W-1:0];
    b_wdata        = {type_r, code_r};
    s_we           = 1'b0;
    s_waddr        = rd_idx_r;
    s_wdata        = '0;
    raddr          = scan_r[ibst_pkg::IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt        = in_cmd;
          idx_nxt        = in_entry_index;
          type_nxt       = in_dev_type;
          code_nxt       = in_dev_code;
          time_nxt       = in_event_time;
          scan_nxt       = '0;
          res_alloc_nxt  = '0;
          res_press_nxt  = 1'b0;
          res_match_nxt  = 1'b0;
          res_status_nxt = ibst_pkg::ST_OK;
          if (in_cmd inside {ibst_pkg::CMD_PRESS, ibst_pkg::CMD_RELEASE,
                             ibst_pkg::CMD_FRAME}) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        state_nxt = S_OUT;
        case (cmd_r)
          ibst_pkg::CMD_ALLOC: begin
            if (count_r == ibst_pkg::CNT_W'(ibst_pkg::TABLE_ENTRIES)) begin
              res_status_nxt = ibst_pkg::ST_FULL;
            end else begin
              b_we          = 1'b1;
              s_we          = 1'b1;
              s_waddr       = count_r[ibst_pkg::IDX_W-1:0];
              s_wdata       = '0;
              res_alloc_nxt = count_r[ibst_pkg::EIDX_W-1:0];
              count_nxt     = count_r + ibst_pkg::CNT_W'(1);
            end
          end
          ibst_pkg::CMD_REBIND: begin
            if (idx_bad) begin
              res_status_nxt = ibst_pkg::ST_BAD_IDX;
            end else begin
              b_we    = 1'b1;
              b_waddr = idx_r[ibst_pkg::IDX_W-1:0];
            end
          end
          ibst_pkg::CMD_QUERY: begin
            if (idx_bad) begin
              res_status_nxt = ibst_pkg::ST_BAD_IDX;
            end else begin
              raddr     = idx_r[ibst_pkg::IDX_W-1:0];
              state_nxt = S_QRD;
            end
          end
          default: begin
            // Unknown commands answer all zero.
          end
        endcase
      end

      S_QRD: begin
        res_press_nxt = !s_rdata[0] && (old_time != '0);
        state_nxt     = S_OUT;
      end

      S_SCAN: begin
        // A frame update clears every released entry it reads back.
        if (cmd_r == ibst_pkg::CMD_FRAME && rd_vld_r && s_rdata[0]) begin
          s_we    = 1'b1;
          s_wdata = '0;
        end
        if (hit) begin
          // First match: update its state and stop the walk.
          res_match_nxt = 1'b1;
          s_we          = 1'b1;
          if (cmd_r == ibst_pkg::CMD_PRESS) begin
            s_wdata = {((time_r > old_time) ? time_r : old_time), s_rdata[0]};
          end else begin
            s_wdata = {old_time, 1'b1};
          end
          state_nxt = S_OUT;
        end else if (scan_r < count_r) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = scan_r[ibst_pkg::IDX_W-1:0];
          scan_nxt   = scan_r + ibst_pkg::CNT_W'(1);
        end else begin
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_alloc_nxt  = res_alloc_r;
          out_press_nxt  = res_press_r;
          out_match_nxt  = res_match_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    idx_r        <= idx_nxt;
    type_r       <= type_nxt;
    code_r       <= code_nxt;
    time_r       <= time_nxt;
    scan_r       <= scan_nxt;
    rd_idx_r     <= rd_idx_nxt;
    res_alloc_r  <= res_alloc_nxt;
    res_press_r  <= res_press_nxt;
    res_match_r  <= res_match_nxt;
    res_status_r <= res_status_nxt;
    out_alloc_r  <= out_alloc_nxt;
    out_press_r  <= out_press_nxt;
    out_match_r  <= out_match_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_alloc_index = out_alloc_r;
  assign out_is_pressed  = out_press_r;
  assign out_matched     = out_match_r;
  assign out_status      = out_status_r;

endmodule

// File: rtl/core/ibst_checker.sv
// ---------------------------------------------------------------------------
// ibst_checker
// Port-level checks of the result channel of the binding table core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "input_binding_state_table_core_assert.svh"

module ibst_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ibst_pkg::EIDX_W-1:0]   out_alloc_index,
  input logic                          out_is_pressed,
  input logic                          out_matched,
  input logic [ibst_pkg::STATUS_W-1:0] out_status
);

  // A stalled result item stays valid and unchanged.
  `IBST_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_alloc_index) && $stable(out_is_pressed) && $stable(out_matched) && $stable(out_status), "result item changed while stalled")

  // The unused status code never appears.
  `IBST_ASSERT_IMP(a_status_code, out_valid, out_status != ibst_pkg::ST_UNUSED, "unused status code")

  // An error result carries no other information.
  `IBST_ASSERT_IMP(a_err_clean, out_valid && (out_status != ibst_pkg::ST_OK), !out_matched && !out_is_pressed && (out_alloc_index == '0), "error result with payload")

  // A matched event is never mixed with a query or an allocation answer.
  `IBST_ASSERT_IMP(a_match_clean, out_valid && out_matched, !out_is_pressed && (out_alloc_index == '0), "matched result mixed with other fields")

endmodule

bind input_binding_state_table_core ibst_checker u_ibst_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_alloc_index (out_alloc_index),
  .out_is_pressed  (out_is_pressed),
  .out_matched     (out_matched),
  .out_status      (out_status)
);
